// ===== sv/ulfp_pkg.sv =====
// Shared types and constants for the UWB location frame parser.
`timescale 1ns / 1ps

package ulfp_pkg;

    localparam logic [7:0] SYNC_BYTE    = 8'hAA;
    localparam logic [7:0] TYPE_BYTE    = 8'h32;
    localparam logic [7:0] VALID_LEN    = 8'h07;
    localparam logic [7:0] HDR_SUM_INIT = 8'h86;
    localparam int         PAYLOAD_LEN  = 8;
    localparam int         IDX_W        = $clog2(PAYLOAD_LEN);
    localparam int         RESULT_W     = 72;

    typedef struct packed {
        logic [15:0]        frame_count;
        logic signed [15:0] pos_z;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_x;
        logic [7:0]         tag_number;
    } result_t;

endpackage

// ===== sv/ulfp_parser.sv =====
// Frame state machine, payload capture, checksum and accepted-frame counter.
`timescale 1ns / 1ps

module ulfp_parser
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       data_byte,
    output logic             res_valid,
    output ulfp_pkg::result_t res
);
    import ulfp_pkg::*;

    typedef enum logic [2:0] {
        HUNT_SYNC0,
        HUNT_SYNC1,
        HUNT_TYPE,
        COLLECT,
        VERIFY_SUM
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [IDX_W-1:0]   index_reg, index_next;
    logic [7:0]         sum_reg, sum_next;
    logic [15:0]        count_reg, count_next;
    logic [7:0]         store_reg [PAYLOAD_LEN];
    logic               frame_ok;

    assign frame_ok = (sum_reg == data_byte) && (store_reg[0] == VALID_LEN);

    always_comb
    begin
        phase_next = phase_reg;
        index_next = index_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        res_valid  = 1'b0;
        if (step)
        begin
            case (phase_reg)
                HUNT_SYNC0:
                begin
                    if (data_byte == SYNC_BYTE)
                    begin
                        phase_next = HUNT_SYNC1;
                    end
                end
                HUNT_SYNC1:
                begin
                    phase_next = (data_byte == SYNC_BYTE) ? HUNT_TYPE : HUNT_SYNC0;
                end
                HUNT_TYPE:
                begin
                    if (data_byte == TYPE_BYTE)
                    begin
                        phase_next = COLLECT;
                        index_next = '0;
                        sum_next   = HDR_SUM_INIT;
                    end
                    else
                    begin
                        phase_next = HUNT_SYNC0;
                    end
                end
                COLLECT:
                begin
                    sum_next = sum_reg + data_byte;
                    if (index_reg == IDX_W'(PAYLOAD_LEN - 1))
                    begin
                        index_next = '0;
                        phase_next = VERIFY_SUM;
                    end
                    else
                    begin
                        index_next = index_reg + 1'b1;
                    end
                end
                VERIFY_SUM:
                begin
                    // advance the counter only for a good frame
                    if (frame_ok)
                    begin
                        count_next = count_reg + 16'd1;
                        res_valid  = 1'b1;
                    end
                    phase_next = HUNT_SYNC0;
                end
                default:
                begin
                    phase_next = HUNT_SYNC0;
                end
            endcase
        end
    end

    always_comb
    begin
        res.tag_number  = store_reg[1];
        res.pos_x       = {store_reg[2], store_reg[3]};
        res.pos_y       = {store_reg[4], store_reg[5]};
        res.pos_z       = {store_reg[6], store_reg[7]};
        res.frame_count = count_reg + 16'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= HUNT_SYNC0;
            index_reg <= '0;
            sum_reg   <= HDR_SUM_INIT;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            index_reg <= index_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

    // payload bytes need no reset; they are read only after a full frame
    always_ff @(posedge clk)
    begin
        if (step && (phase_reg == COLLECT))
        begin
            store_reg[index_reg] <= data_byte;
        end
    end

endmodule

// ===== sv/ulfp_out_reg.sv =====
// Result register on the master side; holds a result until its beat completes.
`timescale 1ns / 1ps

module ulfp_out_reg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic                        res_valid,
    input  ulfp_pkg::result_t           res,
    output logic                        m_tvalid,
    output logic [ulfp_pkg::RESULT_W-1:0] m_tdata
);
    import ulfp_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res_valid)
        begin
            data_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

// ===== sv/uwb_location_frame_parser.sv =====
// Top level of the UWB location frame parser: input register, parser, result register.
`timescale 1ns / 1ps
//
// Usage:
//   Feed received serial bytes on the slave stream (s_tvalid/s_tready/s_tdata),
//   one byte per beat. The block hunts for the header AA AA 32, captures eight
//   payload bytes (length, tag, X, Y, Z big-endian) and checks the 8-bit
//   additive checksum that follows. A frame with a good checksum and length 7
//   yields one beat on the master stream (m_tvalid/m_tready/m_tdata) with tag,
//   X, Y, Z and the wrapping 16-bit count of accepted frames. Bad frames are
//   dropped without any output.
//   Throughput: one byte per cycle, sustained, as long as the master side
//   drains results. The checksum byte first waits in the input register; the
//   parser's result for it is then registered in the result register, which
//   raises m_tvalid.
//   Reset (rst_n low, asynchronous) clears the parser to header hunting, the
//   frame counter to zero and both register stages to empty.
//   When the receiver stalls with a result pending, an empty input register
//   still takes one more byte; after that s_tready drops until the result leaves.
//
module uwb_location_frame_parser
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] data_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [7:0] tag_number, [23:8] pos_x, [39:24] pos_y, [55:40] pos_z,
    // [71:56] frame_count
    output logic [ulfp_pkg::RESULT_W-1:0] m_tdata
);
    import ulfp_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       advance;
    logic       step;
    logic       res_valid;
    result_t    res;

    // the parse stage moves whenever the result register is free or draining
    assign advance  = !m_tvalid || m_tready;
    assign step     = advance && in_valid_reg;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    ulfp_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // hold the result until its beat completes
    ulfp_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .res_valid (res_valid),
        .res       (res),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== sv/ulfp_checker.sv =====
// Port-level checks for the UWB location frame parser, bound to the top level.
`timescale 1ns / 1ps

module ulfp_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata
);
    logic [15:0] seen_reg;
    logic        out_beat;
    logic        in_beat;

    assign out_beat = m_tvalid && m_tready;
    assign in_beat  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
        end
        else if (out_beat)
        begin
            seen_reg <= seen_reg + 16'd1;
        end
    end

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // frame counts run one up per delivered frame
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat |-> (m_tdata[71:56] == seen_reg + 16'd1))
        else $error("frame count out of sequence");

    // an empty result register never blocks input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with no result pending");

    // a new result follows its checksum byte through the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(in_beat, 2))
        else $error("result without a matching input beat");

endmodule

bind uwb_location_frame_parser ulfp_checker u_ulfp_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
